FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property macros for the nearest-pair search core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define VTNR_ASSERT(lbl, clk_sig, rst_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("%m: assertion failed");
// The condition must never be true outside reset.
`define VTNR_ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define VTNR_ASSERT(lbl, clk_sig, rst_sig, prop)
`define VTNR_ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)
`endif
`endif

FILE: src/vtnr_pkg.sv
// ----------------------------------------------------------------------------
// vtnr_pkg
// Widths, codes, shared types and the two-smallest update used by the core.
// ----------------------------------------------------------------------------
package vtnr_pkg;

    localparam int COORD_W    = 16;
    localparam int SQ_W       = 2 * (COORD_W + 1);
    localparam int DIST_W     = SQ_W + 2;
    localparam int GRID_W     = 11;
    localparam int VOX_W      = 10;
    localparam int CNT_W      = 9;
    localparam int IDX_W      = 8;
    localparam int RATIO_W    = 17;
    localparam int QUOT_W     = 16;
    localparam int CFG_DATA_W = 11;
    localparam int ENTRY_W    = 3 * COORD_W;
    localparam int IMAGES     = 27;
    localparam int DRAIN_CYCLES = IMAGES + 3;
    localparam int DRAIN_W    = $clog2(DRAIN_CYCLES + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Image codes per axis: shifted by minus one box, unshifted, plus one box.
    localparam logic [1:0] IMG_NEG = 2'd0;
    localparam logic [1:0] IMG_MID = 2'd1;
    localparam logic [1:0] IMG_POS = 2'd2;

    localparam logic [COORD_W-1:0] CENTER_LO = COORD_W'(1) << (COORD_W - 1);
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << QUOT_W;

    typedef enum logic [0:0] {
        CFG_GRID_SIZE     = 1'b0,
        CFG_NUCLEUS_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0][SQ_W-1:0] sx;
        logic [2:0][SQ_W-1:0] sy;
        logic [2:0][SQ_W-1:0] sz;
    } axis_sq_t;

    typedef struct packed {
        logic              have_best;
        logic              have_second;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
    } top2_t;

    localparam top2_t TOP2_EMPTY = '0;

    // Keeps the smallest value and the smallest one strictly above it.
    function automatic top2_t top2_update(input top2_t p, input logic [DIST_W-1:0] d);
        top2_t r;
        r = p;
        if (!p.have_best)
        begin
            r.have_best = 1'b1;
            r.best      = d;
        end
        else if (d < p.best)
        begin
            r.second      = p.best;
            r.have_second = 1'b1;
            r.best        = d;
        end
        else if ((d > p.best) && (!p.have_second || (d < p.second)))
        begin
            r.second      = d;
            r.have_second = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/vtnr_ram.sv
// ----------------------------------------------------------------------------
// vtnr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vtnr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/vtnr_div.sv
// ----------------------------------------------------------------------------
// vtnr_div
// Restoring divider, one quotient bit per cycle, remainder kept below divisor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtnr_div #(
    parameter int DW = 11,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] rem_init,
    input  logic [DW-1:0] den,
    input  logic [QW-1:0] lo_bits,
    output logic          busy,
    output logic [QW-1:0] quot
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] lo_reg;
    logic [QW-1:0] q_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb
    begin
        trial    = {rem_reg, lo_reg[QW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            den_reg <= den;
            lo_reg  <= lo_bits;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

    `VTNR_ASSERT_NEVER(a_rem_below_den, clk, rst_n, busy_reg && (rem_reg >= den_reg))
    `VTNR_ASSERT_NEVER(a_busy_count, clk, rst_n, busy_reg && (cnt_reg == '0))

endmodule

FILE: src/vtnr_cell.sv
// ----------------------------------------------------------------------------
// vtnr_cell
// One periodic image: forms its squared distance and merges it into the
// running nearest pair handed along the chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtnr_cell #(
    parameter int OX = 1,
    parameter int OY = 1,
    parameter int OZ = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vtnr_pkg::axis_sq_t in_sq,
    input  vtnr_pkg::top2_t    in_top2,
    output logic               out_valid,
    output vtnr_pkg::axis_sq_t out_sq,
    output vtnr_pkg::top2_t    out_top2
);

    import vtnr_pkg::*;

    logic              valid_reg;
    axis_sq_t          sq_reg;
    top2_t             top2_reg;
    top2_t             top2_next;
    logic [DIST_W-1:0] img_dist;

    always_comb
    begin
        img_dist = DIST_W'(in_sq.sx[OX]) + DIST_W'(in_sq.sy[OY]) + DIST_W'(in_sq.sz[OZ]);
        top2_next = top2_update(in_top2, img_dist);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= in_sq;
        top2_reg <= top2_next;
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_top2  = top2_reg;

    `VTNR_ASSERT(a_pair_ordered, clk, rst_n,
        valid_reg && top2_reg.have_second |-> top2_reg.have_best && (top2_reg.best < top2_reg.second))

endmodule

FILE: src/voronoi_two_nearest_ratio_core.sv
// ----------------------------------------------------------------------------
// voronoi_two_nearest_ratio_core
// Periodic nearest and second-nearest nucleus search with distance ratio.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | contents
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | op, nucleus slot and position, voxel
//  out     | out       | out_valid/out_ready  | ratio, two distances, index_error
//
// A load request is written into the table when it is accepted. A query for
// N nuclei runs the voxel center dividers, then N table reads, then drains the
// 27-cell image chain, then runs the ratio divider when a second distance exists.
// A query with a bad voxel index goes straight to the result. Requests are taken
// one at a time; a finished result waits in the output register while the next
// request is accepted. Reset clears control state; the table is undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voronoi_two_nearest_ratio_core #(
    parameter int MAX_NUCLEI = 256,
    parameter int MAX_GRID   = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  vtnr_pkg::cfg_index_t                 cfg_index,
    input  logic [vtnr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 op,
    input  logic [vtnr_pkg::IDX_W-1:0]           nucleus_index,
    input  logic [vtnr_pkg::COORD_W-1:0]         nucleus_x,
    input  logic [vtnr_pkg::COORD_W-1:0]         nucleus_y,
    input  logic [vtnr_pkg::COORD_W-1:0]         nucleus_z,
    input  logic [vtnr_pkg::VOX_W-1:0]           voxel_i,
    input  logic [vtnr_pkg::VOX_W-1:0]           voxel_j,
    input  logic [vtnr_pkg::VOX_W-1:0]           voxel_k,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [vtnr_pkg::RATIO_W-1:0]         distance_ratio,
    output logic [vtnr_pkg::DIST_W-1:0]          nearest_sq_distance,
    output logic [vtnr_pkg::DIST_W-1:0]          second_sq_distance,
    output logic                                 index_error
);

    import vtnr_pkg::*;

    localparam int AW = (MAX_NUCLEI > 1) ? $clog2(MAX_NUCLEI) : 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CENTER = 6'b000010,
        ST_WALK   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_RATIO  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [GRID_W-1:0]   grid_size_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [GRID_W-1:0]   g_eff;
    logic [CNT_W-1:0]    cnt_eff;
    logic [CNT_W-1:0]    walk_idx_reg;
    logic [DRAIN_W-1:0]  drain_cnt_reg;
    logic                err_reg;
    logic                accept;
    logic                idx_bad;
    logic                load_we;
    logic                query_go;
    logic                rd_en;
    logic                rd_valid_reg;
    logic [ENTRY_W-1:0]  rd_data;
    logic                sq_valid_reg;
    axis_sq_t            sq_reg;
    axis_sq_t            sq_next;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [COORD_W-1:0]  cz;
    logic                busy_x;
    logic                busy_y;
    logic                busy_z;
    logic                cdiv_busy;
    logic                rdiv_start;
    logic                rdiv_busy;
    logic [QUOT_W-1:0]   rdiv_q;
    top2_t               acc_reg;
    top2_t               merge_a;
    top2_t               merge_b;
    logic                out_load;
    logic                out_valid_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [DIST_W-1:0]   nearest_reg;
    logic [DIST_W-1:0]   second_reg;
    logic                error_out_reg;

    logic                chain_v  [IMAGES+1];
    axis_sq_t            chain_sq [IMAGES+1];
    top2_t               chain_t2 [IMAGES+1];

    // Squared axis distance from a center to one image of a coordinate.
    function automatic logic [SQ_W-1:0] img_sq(input logic [COORD_W-1:0] c,
                                               input logic [COORD_W-1:0] n,
                                               input logic [1:0] img);
        logic [COORD_W+1:0] d;
        logic [COORD_W:0]   mag;
        logic [SQ_W-1:0]    prod;
        d = {2'b00, c} - {2'b00, n};
        case (img)
            IMG_NEG: d = d + ((COORD_W + 2)'(1) << COORD_W);
            IMG_POS: d = d - ((COORD_W + 2)'(1) << COORD_W);
            default: d = d;
        endcase
        mag  = d[COORD_W+1] ? (COORD_W + 1)'(-d) : d[COORD_W:0];
        prod = mag * mag;
        return prod;
    endfunction

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_W'(64);
            count_reg     <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_SIZE:     grid_size_reg <= cfg_data[GRID_W-1:0];
                CFG_NUCLEUS_COUNT: count_reg     <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign g_eff   = (int'(grid_size_reg) > MAX_GRID) ? GRID_W'(MAX_GRID) : grid_size_reg;
    assign cnt_eff = (int'(count_reg) > MAX_NUCLEI) ? CNT_W'(MAX_NUCLEI) : count_reg;

    // ---------------- request intake ----------------
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_we  = accept && (op == OP_LOAD) && (int'(nucleus_index) < MAX_NUCLEI);
    assign query_go = accept && (op == OP_QUERY);
    assign idx_bad  = (GRID_W'(voxel_i) >= g_eff) || (GRID_W'(voxel_j) >= g_eff)
                   || (GRID_W'(voxel_k) >= g_eff);

    // ---------------- nucleus table ----------------
    assign rd_en = (state_reg == ST_WALK) && (walk_idx_reg != cnt_eff);

    vtnr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NUCLEI)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_we),
        .wr_addr (AW'(nucleus_index)),
        .wr_data ({nucleus_x, nucleus_y, nucleus_z}),
        .rd_en   (rd_en),
        .rd_addr (AW'(walk_idx_reg)),
        .rd_data (rd_data)
    );

    // ---------------- voxel center dividers ----------------
    vtnr_div #(.DW(GRID_W), .QW(COORD_W)) u_cdiv_x (
        .clk (clk), .rst_n (rst_n), .start (query_go && !idx_bad),
        .rem_init (GRID_W'(voxel_i)), .den (g_eff), .lo_bits (CENTER_LO),
        .busy (busy_x), .quot (cx)
    );

    vtnr_div #(.DW(GRID_W), .QW(COORD_W)) u_cdiv_y (
        .clk (clk), .rst_n (rst_n), .start (query_go && !idx_bad),
        .rem_init (GRID_W'(voxel_j)), .den (g_eff), .lo_bits (CENTER_LO),
        .busy (busy_y), .quot (cy)
    );

    vtnr_div #(.DW(GRID_W), .QW(COORD_W)) u_cdiv_z (
        .clk (clk), .rst_n (rst_n), .start (query_go && !idx_bad),
        .rem_init (GRID_W'(voxel_k)), .den (g_eff), .lo_bits (CENTER_LO),
        .busy (busy_z), .quot (cz)
    );

    assign cdiv_busy = busy_x || busy_y || busy_z;

    // ---------------- axis squares stage ----------------
    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            sq_next.sx[m] = img_sq(cx, rd_data[3*COORD_W-1:2*COORD_W], 2'(m));
            sq_next.sy[m] = img_sq(cy, rd_data[2*COORD_W-1:COORD_W], 2'(m));
            sq_next.sz[m] = img_sq(cz, rd_data[COORD_W-1:0], 2'(m));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            sq_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // ---------------- image chain ----------------
    assign chain_v[0]  = sq_valid_reg;
    assign chain_sq[0] = sq_reg;
    assign chain_t2[0] = TOP2_EMPTY;

    for (genvar k = 0; k < IMAGES; k++)
    begin : g_cell
        vtnr_cell #(
            .OX (k / 9),
            .OY ((k / 3) % 3),
            .OZ (k % 3)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_v[k]),
            .in_sq     (chain_sq[k]),
            .in_top2   (chain_t2[k]),
            .out_valid (chain_v[k+1]),
            .out_sq    (chain_sq[k+1]),
            .out_top2  (chain_t2[k+1])
        );
    end

    // Merging a nucleus's own pair gives the same two smallest distinct values
    // as feeding all of its 27 distances.
    always_comb
    begin
        merge_a = chain_t2[IMAGES].have_best
                ? top2_update(acc_reg, chain_t2[IMAGES].best) : acc_reg;
        merge_b = chain_t2[IMAGES].have_second
                ? top2_update(merge_a, chain_t2[IMAGES].second) : merge_a;
    end

    // ---------------- ratio divider ----------------
    assign rdiv_start = (state_reg == ST_DRAIN) && (drain_cnt_reg == '0) && acc_reg.have_second;

    vtnr_div #(.DW(DIST_W), .QW(QUOT_W)) u_rdiv (
        .clk (clk), .rst_n (rst_n), .start (rdiv_start),
        .rem_init (acc_reg.best), .den (acc_reg.second), .lo_bits ('0),
        .busy (rdiv_busy), .quot (rdiv_q)
    );

    // ---------------- sequencer ----------------
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = idx_bad ? ST_RESULT : ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                if (!cdiv_busy)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_idx_reg == cnt_eff)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_cnt_reg == '0)
                begin
                    state_next = acc_reg.have_second ? ST_RATIO : ST_RESULT;
                end
            end
            ST_RATIO:
            begin
                if (!rdiv_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_idx_reg  <= '0;
            drain_cnt_reg <= '0;
            err_reg       <= 1'b0;
            acc_reg       <= TOP2_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
            if (query_go)
            begin
                err_reg <= idx_bad;
            end
            if (state_reg == ST_CENTER)
            begin
                walk_idx_reg <= '0;
                acc_reg      <= TOP2_EMPTY;
            end
            else
            begin
                if (rd_en)
                begin
                    walk_idx_reg <= walk_idx_reg + 1'b1;
                end
                if (chain_v[IMAGES])
                begin
                    acc_reg <= merge_b;
                end
            end
            if ((state_reg == ST_WALK) && (walk_idx_reg == cnt_eff))
            begin
                drain_cnt_reg <= DRAIN_W'(DRAIN_CYCLES);
            end
            else if ((state_reg == ST_DRAIN) && (drain_cnt_reg != '0))
            begin
                drain_cnt_reg <= drain_cnt_reg - 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (err_reg)
            begin
                ratio_reg     <= '0;
                nearest_reg   <= '0;
                second_reg    <= '0;
                error_out_reg <= 1'b1;
            end
            else
            begin
                ratio_reg     <= acc_reg.have_second ? {1'b0, rdiv_q} : RATIO_ONE;
                nearest_reg   <= acc_reg.have_best ? acc_reg.best : '0;
                second_reg    <= acc_reg.have_second ? acc_reg.second : '0;
                error_out_reg <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign distance_ratio      = ratio_reg;
    assign nearest_sq_distance = nearest_reg;
    assign second_sq_distance  = second_reg;
    assign index_error         = error_out_reg;

    `VTNR_ASSERT(a_error_zero, clk, rst_n, out_valid_reg && error_out_reg |-> (ratio_reg == '0) && (nearest_reg == '0) && (second_reg == '0))
    `VTNR_ASSERT(a_second_above, clk, rst_n, out_valid_reg && (second_reg != '0) |-> (nearest_reg < second_reg) && !ratio_reg[RATIO_W-1])
    `VTNR_ASSERT(a_chain_empty, clk, rst_n, (state_reg == ST_DRAIN) && (drain_cnt_reg == '0) |-> !rd_valid_reg && !sq_valid_reg && !chain_v[IMAGES])

endmodule

FILE: bench/search_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// search_monitor
// Watches the configuration, request and result channels of the periodic
// nearest-pair search core. It keeps its own nucleus table and register copies,
// predicts each query result and compares it field by field with the block.
// ----------------------------------------------------------------------------
module search_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  vtnr_pkg::cfg_index_t               cfg_index,
    input  logic [vtnr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               op,
    input  logic [vtnr_pkg::IDX_W-1:0]         nucleus_index,
    input  logic [vtnr_pkg::COORD_W-1:0]       nucleus_x,
    input  logic [vtnr_pkg::COORD_W-1:0]       nucleus_y,
    input  logic [vtnr_pkg::COORD_W-1:0]       nucleus_z,
    input  logic [vtnr_pkg::VOX_W-1:0]         voxel_i,
    input  logic [vtnr_pkg::VOX_W-1:0]         voxel_j,
    input  logic [vtnr_pkg::VOX_W-1:0]         voxel_k,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [vtnr_pkg::RATIO_W-1:0]       distance_ratio,
    input  logic [vtnr_pkg::DIST_W-1:0]        nearest_sq_distance,
    input  logic [vtnr_pkg::DIST_W-1:0]        second_sq_distance,
    input  logic                               index_error,
    output int                                 error_count,
    output int                                 pending_count
);
    import vtnr_pkg::*;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [DIST_W-1:0]  nearest;
        logic [DIST_W-1:0]  second;
        logic               err;
    } search_result_t;

    logic [COORD_W-1:0] pos_x [256];
    logic [COORD_W-1:0] pos_y [256];
    logic [COORD_W-1:0] pos_z [256];
    logic [GRID_W-1:0]  grid_reg;
    logic [CNT_W-1:0]   count_reg;
    search_result_t     expected_results [$];

    assign pending_count = expected_results.size();

    function automatic longint unsigned image_sq(input longint c, input longint n, input int off);
        longint d;
        d = c - n - longint'(off) * 65536;
        return longint'(d * d);
    endfunction

    function automatic search_result_t nearest_pair(input logic [VOX_W-1:0] vi,
                                                    input logic [VOX_W-1:0] vj,
                                                    input logic [VOX_W-1:0] vk);
        search_result_t r;
        longint unsigned g, cx, cy, cz, d, best, sec;
        int cnt;
        bit have_best, have_sec;
        r = '0;
        g = (grid_reg > 1024) ? 1024 : grid_reg;
        cnt = (count_reg > 256) ? 256 : count_reg;
        best = 0;
        sec = 0;
        have_best = 0;
        have_sec = 0;
        if (vi >= g || vj >= g || vk >= g)
        begin
            r.err = 1'b1;
            return r;
        end
        cx = ((longint'(vi) * 2 + 1) << 15) / g;
        cy = ((longint'(vj) * 2 + 1) << 15) / g;
        cz = ((longint'(vk) * 2 + 1) << 15) / g;
        for (int w = 0; w < cnt; w++)
            for (int ox = -1; ox <= 1; ox++)
                for (int oy = -1; oy <= 1; oy++)
                    for (int oz = -1; oz <= 1; oz++)
                    begin
                        d = image_sq(cx, pos_x[w], ox) + image_sq(cy, pos_y[w], oy)
                          + image_sq(cz, pos_z[w], oz);
                        if (!have_best)
                        begin
                            best = d;
                            have_best = 1;
                        end
                        else if (d < best)
                        begin
                            sec = best;
                            have_sec = 1;
                            best = d;
                        end
                        else if (d > best && (!have_sec || d < sec))
                        begin
                            sec = d;
                            have_sec = 1;
                        end
                    end
        r.nearest = best[DIST_W-1:0];
        if (have_sec)
        begin
            r.ratio  = RATIO_W'((best << 16) / sec);
            r.second = sec[DIST_W-1:0];
        end
        else
            r.ratio = RATIO_ONE;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        search_result_t want;
        if (!rst_n)
        begin
            grid_reg    <= GRID_W'(64);
            count_reg   <= CNT_W'(1);
            error_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GRID_SIZE)
                    grid_reg <= cfg_data[GRID_W-1:0];
                else
                    count_reg <= cfg_data[CNT_W-1:0];
            end
            if (in_valid && in_ready)
            begin
                if (op == OP_LOAD)
                begin
                    pos_x[nucleus_index] = nucleus_x;
                    pos_y[nucleus_index] = nucleus_y;
                    pos_z[nucleus_index] = nucleus_z;
                end
                else
                    expected_results.push_back(nearest_pair(voxel_i, voxel_j, voxel_k));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("monitor: result with no query outstanding at %0t", $realtime);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.ratio !== distance_ratio || want.nearest !== nearest_sq_distance
                        || want.second !== second_sq_distance || want.err !== index_error)
                    begin
                        if (error_count < 10)
                            $display("monitor: mismatch ratio %0d/%0d near %0d/%0d sec %0d/%0d err %0b/%0b",
                                     want.ratio, distance_ratio, want.nearest,
                                     nearest_sq_distance, want.second, second_sq_distance,
                                     want.err, index_error);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives nucleus loads, voxel queries and register writes into the periodic
// nearest-pair search core, with random idling on both sides and one long
// result stall, and reports the verdict from the monitor's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
    import vtnr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [IDX_W-1:0]      nucleus_index;
    logic [COORD_W-1:0]    nucleus_x, nucleus_y, nucleus_z;
    logic [VOX_W-1:0]      voxel_i, voxel_j, voxel_k;
    logic                  out_valid;
    logic                  out_ready;
    logic [RATIO_W-1:0]    distance_ratio;
    logic [DIST_W-1:0]     nearest_sq_distance, second_sq_distance;
    logic                  index_error;
    int                    error_count;
    int                    pending_count;
    logic [255:0]          loaded;
    int                    request_count;

    voronoi_two_nearest_ratio_core dut (.*);
    search_monitor monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // Short bursts with no idling alternate with random gaps.
    function automatic int draw_gap();
        if ((request_count / 40) % 4 == 0)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    task automatic send_request(input logic kind, input int slot, input logic [15:0] x,
                                input logic [15:0] y, input logic [15:0] z,
                                input int vi, input int vj, input int vk);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op            = kind;
        nucleus_index = IDX_W'(slot);
        nucleus_x     = x;
        nucleus_y     = y;
        nucleus_z     = z;
        voxel_i       = VOX_W'(vi);
        voxel_j       = VOX_W'(vj);
        voxel_k       = VOX_W'(vk);
        in_valid      = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        request_count++;
        if (kind == OP_LOAD)
            loaded[slot] = 1'b1;
    endtask

    task automatic load_nucleus(input int slot, input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z);
        send_request(OP_LOAD, slot, x, y, z, $urandom, $urandom, $urandom);
    endtask

    task automatic query_voxel(input int vi, input int vj, input int vk);
        send_request(OP_QUERY, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                     vi, vj, vk);
    endtask

    // Waits until every result is back, then lets a trailing load finish.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input int value);
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int grid, input int cnt, input int budget);
        int geff, ceff;
        settle();
        write_register(CFG_GRID_SIZE, grid);
        write_register(CFG_NUCLEUS_COUNT, cnt);
        geff = (grid > 1024) ? 1024 : grid;
        ceff = (cnt > 256) ? 256 : cnt;
        for (int s = 0; s < ceff; s++)
            if (!loaded[s])
                load_nucleus(s, pick_coord(), pick_coord(), pick_coord());
        repeat (budget)
        begin
            if ($urandom_range(0, 3) == 0)
                load_nucleus($urandom_range(0, 255), pick_coord(), pick_coord(), pick_coord());
            else if (geff > 0 && $urandom_range(0, 4) != 0)
                query_voxel($urandom_range(0, geff - 1), $urandom_range(0, geff - 1),
                            $urandom_range(0, geff - 1));
            else
                query_voxel($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
        end
    endtask

    // Result side: random gaps, plus one long hold-off so the core backs up.
    initial
    begin
        int gap;
        int results;
        results   = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = 1'b0;
            if (results == 40)
                repeat (3000) @(negedge clk);
            else
            begin
                gap = ((results / 30) % 4 == 1) ? 0 : $urandom_range(0, 5);
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results++;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GRID_SIZE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        op            = OP_LOAD;
        nucleus_index = '0;
        nucleus_x     = '0;
        nucleus_y     = '0;
        nucleus_z     = '0;
        voxel_i       = '0;
        voxel_j       = '0;
        voxel_k       = '0;
        loaded        = '0;
        request_count = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part with the reset settings: grid 64, one nucleus.
        load_nucleus(0, 16'd0, 16'd0, 16'd0);
        query_voxel(0, 0, 0);
        load_nucleus(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        query_voxel(63, 63, 63);
        query_voxel(64, 0, 0);
        query_voxel(0, 0, 1023);
        settle();
        write_register(CFG_NUCLEUS_COUNT, 3);
        // Two identical nuclei give tied nearest distances.
        load_nucleus(1, 16'h8000, 16'h8000, 16'h8000);
        load_nucleus(2, 16'h8000, 16'h8000, 16'h8000);
        query_voxel(31, 31, 31);
        query_voxel(0, 31, 63);
        settle();
        write_register(CFG_NUCLEUS_COUNT, 0);
        query_voxel(5, 6, 7);
        settle();
        write_register(CFG_GRID_SIZE, 0);
        query_voxel(0, 0, 0);
        settle();
        write_register(CFG_GRID_SIZE, 1);
        write_register(CFG_NUCLEUS_COUNT, 1);
        query_voxel(0, 0, 0);
        query_voxel(1, 0, 0);

        // Random phases over a spread of register settings.
        run_phase(64, 4, 130);
        run_phase(1024, 16, 130);
        run_phase(1, 1, 100);
        run_phase(2047, 511, 40);
        run_phase(0, 8, 40);
        run_phase(2, 2, 120);
        run_phase(3, 256, 40);
        run_phase(1024, 1, 100);
        repeat (3)
            run_phase($urandom_range(1, 1024), $urandom_range(1, 32), 100);

        settle();
        repeat (200) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: voronoi_two_nearest_ratio_core.f
+incdir+src
src/vtnr_pkg.sv
src/vtnr_ram.sv
src/vtnr_div.sv
src/vtnr_cell.sv
src/voronoi_two_nearest_ratio_core.sv
bench/search_monitor.sv
bench/testbench.sv
